### sv/lhm_pkg.sv
// ----------------------------------------------------------------------------
// lhm_pkg
// shared widths, types and the bucket value function of the log histogram
// ----------------------------------------------------------------------------
package lhm_pkg;

	localparam int LHM_TOP_LEVELS = 32;
	localparam int SUB_LEVELS     = 64;
	localparam int SUB_SHIFT      = 6;

	localparam int IDX_W  = 11;
	localparam int CNT_W  = 32;
	localparam int TOT_W  = 64;
	localparam int CLIP_W = 32;
	localparam int FRAC_W = 17;
	localparam int CVAL_W = 38;
	localparam int CUM_W  = CNT_W + IDX_W;
	localparam int Q_SHIFT = 16;

	localparam int S_TDATA_W = 288;
	localparam int M_FIELD_W = 1 + IDX_W + CVAL_W + 3 * TOT_W + CLIP_W;
	localparam int M_TDATA_W = 280;

	typedef enum logic [1:0] {
		MODE_MERGE_BUCKET = 2'd0,
		MODE_MERGE_TOTALS = 2'd1,
		MODE_QUERY        = 2'd2,
		MODE_NONE         = 2'd3
	} mode_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [CNT_W-1:0] data;
	} ram_wr_t;

	// representative cycle value of a bucket
	function automatic logic [CVAL_W-1:0] bucket_value(input logic [IDX_W-1:0] idx);
		logic [IDX_W-SUB_SHIFT-1:0] top;
		logic [5:0]                 sh_hi;
		logic [CVAL_W-1:0]          sub;
		logic [CVAL_W-1:0]          v;
		top   = idx[IDX_W-1:SUB_SHIFT];
		sub   = CVAL_W'(idx[SUB_SHIFT-1:0]);
		sh_hi = 6'(top) + 6'(SUB_SHIFT - 1);
		if (top == '0) begin
			v = sub;
		end else begin
			v = (CVAL_W'(1) << sh_hi) | (sub << (top - 1'b1));
			if (top >= 2) begin
				v = v | (CVAL_W'(1) << (top - 2'd2));
			end
		end
		return v;
	endfunction

endpackage

### sv/lhm_bucket_ram.sv
// ----------------------------------------------------------------------------
// lhm_bucket_ram
// bucket counter memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lhm_bucket_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  lhm_pkg::ram_wr_t          wr,
	input  logic [lhm_pkg::IDX_W-1:0] raddr,
	output logic [lhm_pkg::CNT_W-1:0] rdata
);
	import lhm_pkg::*;

	logic [CNT_W-1:0] mem_q [DEPTH];
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
		rdata_q <= mem_q[raddr[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule

### sv/log_histogram_merge_percentile_top.sv
// ----------------------------------------------------------------------------
// log_histogram_merge_percentile_top
// log-scaled latency histogram with bucket merge, totals merge and percentile
// query
// ----------------------------------------------------------------------------
// input words come in on s_tvalid/s_tready with the mode in s_tuser; one
// result word per input word leaves on m_tvalid/m_tready.
// after reset the block sweeps the bucket memory to zero, one entry a cycle
// (TOP_LEVELS*64 entries, at most 2048); s_tready stays low meanwhile.
// one word is worked on at a time; s_tready is high only while idle.
// steps from accept to result loaded: bucket merge reads the memory, then
// writes it back; totals merge updates the totals; other mode or
// out-of-range merge goes straight to done; query forms the threshold from
// two multiplier halves, then, if it fits in 64 bits, scans the buckets in
// order up to the hit (at most TOP_LEVELS*64, capped at 2048), bounded by the
// single memory read port and the one running adder/compare. each load returns to idle.
// the result sits in an output register: the next word is taken while it
// waits, and that word's result waits in turn until m_tready takes the first.
// ----------------------------------------------------------------------------
module log_histogram_merge_percentile_top #(
	parameter int TOP_LEVELS = lhm_pkg::LHM_TOP_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// bucket_index_in, add_count, samples_in, cycles_in, max_in, clipped_in, fraction
	input  logic [lhm_pkg::S_TDATA_W-1:0] s_tdata,
	// mode
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found, bucket_index, cycles_value, sample_count, cycle_sum, max_cycles,
	// clipped_count
	output logic [lhm_pkg::M_TDATA_W-1:0] m_tdata
);
	import lhm_pkg::*;

	localparam int NUM_BUCKETS = TOP_LEVELS * SUB_LEVELS;
	localparam int MEM_DEPTH   = (NUM_BUCKETS > (1 << IDX_W)) ? (1 << IDX_W) : NUM_BUCKETS;
	localparam int AW          = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(MEM_DEPTH - 1);
	localparam logic [IDX_W:0]   NB_LIMIT  = (IDX_W + 1)'(NUM_BUCKETS);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_MRD   = 10'b0000000100,
		ST_MWR   = 10'b0000001000,
		ST_TOT   = 10'b0000010000,
		ST_MLO   = 10'b0000100000,
		ST_MHI   = 10'b0001000000,
		ST_THR   = 10'b0010000000,
		ST_SCAN  = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	// input fields
	logic [IDX_W-1:0]  in_idx;
	logic [CNT_W-1:0]  in_add;
	logic [TOT_W-1:0]  in_samples;
	logic [TOT_W-1:0]  in_cycles;
	logic [TOT_W-1:0]  in_max;
	logic [CLIP_W-1:0] in_clip;
	logic [FRAC_W-1:0] in_frac;
	mode_t             in_mode;

	assign in_idx     = s_tdata[10:0];
	assign in_add     = s_tdata[42:11];
	assign in_samples = s_tdata[106:43];
	assign in_cycles  = s_tdata[170:107];
	assign in_max     = s_tdata[234:171];
	assign in_clip    = s_tdata[266:235];
	assign in_frac    = s_tdata[283:267];
	assign in_mode    = mode_t'(s_tuser);

	// latched item
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  add_q;
	logic [TOT_W-1:0]  samples_q;
	logic [TOT_W-1:0]  cycles_q;
	logic [TOT_W-1:0]  max_in_q;
	logic [CLIP_W-1:0] clip_in_q;
	logic [FRAC_W-1:0] frac_q;

	// running totals
	logic [TOT_W-1:0]  sample_total_q;
	logic [TOT_W-1:0]  cycle_total_q;
	logic [TOT_W-1:0]  max_seen_q;
	logic [CLIP_W-1:0] clipped_total_q;

	// query datapath
	logic [FRAC_W+31:0] prod_lo_q;
	logic [FRAC_W+31:0] prod_hi_q;
	logic [TOT_W-1:0]   thr_q;
	logic               thr_big_q;
	logic [AW-1:0]      addr_q;
	logic               issue_q;
	logic               dv_q;
	logic [AW-1:0]      didx_q;
	logic [CUM_W-1:0]   cum_q;
	logic               found_q;
	logic [IDX_W-1:0]   bidx_q;

	logic                 out_valid_q;
	logic [M_FIELD_W-1:0] out_q;

	ram_wr_t          ram_wr;
	logic [IDX_W-1:0] ram_raddr;
	logic [CNT_W-1:0] ram_rdata;

	logic                    accept;
	logic                    load;
	logic [CNT_W:0]          merge_sum;
	logic [CNT_W-1:0]        merge_sat;
	logic [31:0]             mul_b;
	logic [FRAC_W+31:0]      prod;
	logic [TOT_W+FRAC_W-1:0] thr_full;
	logic [CUM_W-1:0]        cum_nx;
	logic                    hit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load     = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign merge_sum = {1'b0, ram_rdata} + {1'b0, add_q};
	assign merge_sat = merge_sum[CNT_W] ? '1 : merge_sum[CNT_W-1:0];

	// one multiplier, low then high half of the sample total
	assign mul_b = (state_q == ST_MHI) ? sample_total_q[TOT_W-1:32] : sample_total_q[31:0];
	assign prod  = (FRAC_W + 32)'(frac_q * mul_b);

	assign thr_full = (TOT_W + FRAC_W)'(prod_lo_q) + ((TOT_W + FRAC_W)'(prod_hi_q) << 32);

	assign cum_nx = cum_q + CUM_W'(ram_rdata);
	assign hit    = TOT_W'({cum_nx, {Q_SHIFT{1'b0}}}) >= thr_q;

	always_comb begin
		ram_wr = '0;
		if (state_q == ST_CLEAR) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = IDX_W'(addr_q);
		end else if (state_q == ST_MWR) begin
			ram_wr.en   = 1'b1;
			ram_wr.addr = idx_q;
			ram_wr.data = merge_sat;
		end
	end

	assign ram_raddr = (state_q == ST_MRD) ? idx_q : IDX_W'(addr_q);

	lhm_bucket_ram #(
		.DEPTH(MEM_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.wr   (ram_wr),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// item latch, multiplier partial products, threshold and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= in_idx;
			add_q     <= in_add;
			samples_q <= in_samples;
			cycles_q  <= in_cycles;
			max_in_q  <= in_max;
			clip_in_q <= in_clip;
			frac_q    <= in_frac;
		end
		if (state_q == ST_MLO) begin
			prod_lo_q <= prod;
		end
		if (state_q == ST_MHI) begin
			prod_hi_q <= prod;
		end
		if (state_q == ST_THR) begin
			thr_q     <= thr_full[TOT_W-1:0];
			thr_big_q <= |thr_full[TOT_W+FRAC_W-1:TOT_W];
		end
		if (load) begin
			out_q <= {clipped_total_q, max_seen_q, cycle_total_q, sample_total_q,
				found_q ? bucket_value(bidx_q) : {CVAL_W{1'b0}}, bidx_q, found_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			addr_q          <= '0;
			issue_q         <= 1'b0;
			dv_q            <= 1'b0;
			didx_q          <= '0;
			cum_q           <= '0;
			found_q         <= 1'b0;
			bidx_q          <= '0;
			sample_total_q  <= '0;
			cycle_total_q   <= '0;
			max_seen_q      <= '0;
			clipped_total_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !m_tready);
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						bidx_q  <= '0;
						unique case (in_mode)
							MODE_MERGE_BUCKET: begin
								state_q <= ({1'b0, in_idx} < NB_LIMIT) ? ST_MRD : ST_DONE;
							end
							MODE_MERGE_TOTALS: state_q <= ST_TOT;
							MODE_QUERY:        state_q <= ST_MLO;
							MODE_NONE:         state_q <= ST_DONE;
							default:           state_q <= ST_DONE;
						endcase
					end
				end
				ST_MRD: state_q <= ST_MWR;
				ST_MWR: state_q <= ST_DONE;
				ST_TOT: begin
					sample_total_q  <= sample_total_q + samples_q;
					cycle_total_q   <= cycle_total_q + cycles_q;
					clipped_total_q <= clipped_total_q + clip_in_q;
					if (max_in_q > max_seen_q) begin
						max_seen_q <= max_in_q;
					end
					state_q <= ST_DONE;
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_THR;
				ST_THR: begin
					addr_q  <= '0;
					issue_q <= 1'b1;
					dv_q    <= 1'b0;
					cum_q   <= '0;
					state_q <= (|thr_full[TOT_W+FRAC_W-1:TOT_W]) ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					dv_q   <= issue_q;
					didx_q <= addr_q;
					if (issue_q) begin
						if (addr_q == LAST_ADDR) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (dv_q) begin
						cum_q <= cum_nx;
						if (hit && !thr_big_q) begin
							found_q <= 1'b1;
							bidx_q  <= IDX_W'(didx_q);
							state_q <= ST_DONE;
						end else if (didx_q == LAST_ADDR) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

endmodule

### verif/log_histogram_merge_percentile_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_histogram_merge_percentile_top_test
// Self-checking testbench for the log histogram with merge and percentile
// query. A predictor holds its own copy of the bucket counters and totals.
// It works out one expected result word for each accepted input word, and a
// monitor compares every result word with the oldest expectation, one field
// at a time. Directed words cover the empty histogram, counter saturation,
// totals wrap, the unused mode and the query edges. Random merge/query
// sequences with consistent sample totals follow. Both sides stall at random.
// ----------------------------------------------------------------------------
module log_histogram_merge_percentile_top_test;
	import lhm_pkg::*;

	localparam int NUM_BINS    = LHM_TOP_LEVELS * SUB_LEVELS;
	localparam int RANDOM_WORDS = 1600;

	typedef struct {
		mode_t             mode;
		logic [IDX_W-1:0]  bidx;
		logic [CNT_W-1:0]  add;
		logic [TOT_W-1:0]  samples;
		logic [TOT_W-1:0]  cycles;
		logic [TOT_W-1:0]  maxv;
		logic [CLIP_W-1:0] clipped;
		logic [FRAC_W-1:0] frac;
	} hist_word_t;

	// packed from the top of m_tdata down to bit 0
	typedef struct packed {
		logic [CLIP_W-1:0] clipped;
		logic [TOT_W-1:0]  maxv;
		logic [TOT_W-1:0]  cycles;
		logic [TOT_W-1:0]  samples;
		logic [CVAL_W-1:0] cval;
		logic [IDX_W-1:0]  bidx;
		logic              found;
	} hist_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]           s_tuser  = MODE_NONE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	logic [CNT_W-1:0]  hist_bins [NUM_BINS];
	logic [TOT_W-1:0]  hist_samples = '0;
	logic [TOT_W-1:0]  hist_cycles  = '0;
	logic [TOT_W-1:0]  hist_max     = '0;
	logic [CLIP_W-1:0] hist_clipped = '0;

	hist_result_t pending_results [$];

	int  errors         = 0;
	int  word_count     = 0;
	int  bucket_merges  = 0;
	int  totals_merges  = 0;
	int  queries        = 0;
	int  queries_found  = 0;
	int  saturations    = 0;
	bit  steady         = 1'b0;

	log_histogram_merge_percentile_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	initial begin
		#150_000_000;
		$display("log_histogram_merge_percentile_top regression: fail");
		$finish;
	end

	function automatic logic [CVAL_W-1:0] bin_cycles(input int idx);
		logic [63:0] top;
		logic [63:0] sub;
		logic [63:0] v;
		top = 64'(idx >> SUB_SHIFT);
		sub = 64'(idx & (SUB_LEVELS - 1));
		if (top == 0) begin
			v = sub;
		end else begin
			v = (64'd1 << (top + 5)) | (sub << (top - 1));
			if (top >= 2) begin
				v = v | (64'd1 << (top - 2));
			end
		end
		return v[CVAL_W-1:0];
	endfunction

	function automatic hist_result_t histogram_apply(input hist_word_t w);
		hist_result_t r;
		logic [CNT_W:0] acc;
		logic [127:0]   need;
		logic [127:0]   cum;
		r = '0;
		case (w.mode)
			MODE_MERGE_BUCKET: begin
				if (int'(w.bidx) < NUM_BINS) begin
					acc = {1'b0, hist_bins[w.bidx]} + {1'b0, w.add};
					if (acc[CNT_W]) begin
						saturations++;
					end
					hist_bins[w.bidx] = acc[CNT_W] ? '1 : acc[CNT_W-1:0];
				end
			end
			MODE_MERGE_TOTALS: begin
				hist_samples = hist_samples + w.samples;
				hist_cycles  = hist_cycles + w.cycles;
				if (w.maxv > hist_max) begin
					hist_max = w.maxv;
				end
				hist_clipped = hist_clipped + w.clipped;
			end
			MODE_QUERY: begin
				need = 128'(w.frac) * 128'(hist_samples);
				cum  = '0;
				for (int i = 0; i < NUM_BINS && !r.found; i++) begin
					cum = cum + 128'(hist_bins[i]);
					if ((cum << Q_SHIFT) >= need) begin
						r.found = 1'b1;
						r.bidx  = IDX_W'(i);
						r.cval  = bin_cycles(i);
					end
				end
			end
			default: begin
			end
		endcase
		r.samples = hist_samples;
		r.cycles  = hist_cycles;
		r.maxv    = hist_max;
		r.clipped = hist_clipped;
		return r;
	endfunction

	function automatic hist_word_t rand_word(input mode_t mode);
		hist_word_t w;
		w.mode    = mode;
		w.bidx    = IDX_W'($urandom);
		w.add     = $urandom;
		w.samples = {$urandom, $urandom};
		w.cycles  = {$urandom, $urandom};
		w.maxv    = {$urandom, $urandom};
		w.clipped = $urandom;
		w.frac    = FRAC_W'($urandom);
		return w;
	endfunction

	task automatic send_word(input hist_word_t w);
		hist_result_t r;
		while (!steady && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= {4'b0, w.frac, w.clipped, w.maxv, w.cycles, w.samples, w.add, w.bidx};
		s_tuser  <= w.mode;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		r = histogram_apply(w);
		pending_results.push_back(r);
		case (w.mode)
			MODE_MERGE_BUCKET: bucket_merges++;
			MODE_MERGE_TOTALS: totals_merges++;
			MODE_QUERY: begin
				queries++;
				queries_found += r.found;
			end
			default: begin
			end
		endcase
		if (w.mode != MODE_NONE) begin
			word_count++;
		end
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic check_result(input hist_result_t got);
		hist_result_t exp;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("%0t: result word with nothing expected: %h", $time, got);
			end
		end else begin
			exp = pending_results.pop_front();
			if (got.found !== exp.found || got.bidx !== exp.bidx || got.cval !== exp.cval
					|| got.samples !== exp.samples || got.cycles !== exp.cycles
					|| got.maxv !== exp.maxv || got.clipped !== exp.clipped) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch found/bidx/cval exp %b %0d %h got %b %0d %h",
						$time, exp.found, exp.bidx, exp.cval, got.found, got.bidx, got.cval);
					$display("  samples/cycles exp %h %h got %h %h",
						exp.samples, exp.cycles, got.samples, got.cycles);
					$display("  max/clipped exp %h %h got %h %h",
						exp.maxv, exp.clipped, got.maxv, got.clipped);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			check_result(m_tdata[M_FIELD_W-1:0]);
		end
		m_tready <= arst_n && (steady || $urandom_range(0, 99) >= 31);
	end

	// empty histogram: threshold is zero, so bucket 0 is always reached
	task automatic test_empty_queries();
		int         fr [3] = '{0, 65536, 131071};
		hist_word_t w;
		foreach (fr[k]) begin
			w      = rand_word(MODE_QUERY);
			w.frac = FRAC_W'(fr[k]);
			send_word(w);
		end
	endtask

	task automatic test_bucket_merge();
		logic [IDX_W-1:0] idx [9] = '{11'd2047, 11'd2047, 11'd1984, 11'd1984, 11'd0,
			11'd63, 11'd64, 11'd128, 11'd129};
		logic [CNT_W-1:0] cnt [9] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4};
		hist_word_t w;
		foreach (idx[k]) begin
			w      = rand_word(MODE_MERGE_BUCKET);
			w.bidx = idx[k];
			w.add  = cnt[k];
			send_word(w);
		end
	endtask

	task automatic test_totals_merge();
		hist_word_t w;
		w         = rand_word(MODE_MERGE_TOTALS);
		w.samples = '1;
		w.cycles  = '1;
		w.maxv    = '1;
		w.clipped = '1;
		send_word(w);
		// wrap of every running total, max holds
		w.samples = 64'd2;
		w.cycles  = 64'd3;
		w.maxv    = 64'd5;
		w.clipped = 32'd7;
		send_word(w);
		// bring the sample total to the sum of the low buckets
		w         = rand_word(MODE_MERGE_TOTALS);
		w.samples = 64'd10 - hist_samples;
		send_word(w);
	endtask

	task automatic test_idle_mode();
		hist_word_t w;
		w         = rand_word(MODE_NONE);
		w.bidx    = '1;
		w.add     = '1;
		w.samples = '1;
		w.maxv    = '1;
		w.frac    = '1;
		send_word(w);
	endtask

	// thresholds landing on top level 0, 1, 2, past 1.0 and out of reach
	task automatic test_query_edges();
		int         fr [5] = '{0, 6554, 65536, 65537, 131071};
		hist_word_t w;
		foreach (fr[k]) begin
			w      = rand_word(MODE_QUERY);
			w.frac = FRAC_W'(fr[k]);
			send_word(w);
		end
		wait_results_drained();
		w         = rand_word(MODE_MERGE_TOTALS);
		w.samples = 64'h8000_0000_0000_0000 - hist_samples;
		send_word(w);
		w      = rand_word(MODE_QUERY);
		w.frac = FRAC_W'(65536);
		send_word(w);
	endtask

	task automatic test_random_sequences();
		hist_word_t       w;
		int               seq_no;
		int               r;
		int               cut;
		logic [TOT_W-1:0] target;
		seq_no = 0;
		while (word_count < RANDOM_WORDS + 25) begin
			steady = (seq_no >= 40 && seq_no < 70);
			if ($urandom_range(0, 99) < 80) begin
				repeat ($urandom_range(2, 12)) begin
					w = rand_word(MODE_MERGE_BUCKET);
					r = $urandom_range(0, 99);
					if (r < 75) begin
						w.bidx = IDX_W'($urandom_range(0, 511));
					end else if (r < 90) begin
						w.bidx = IDX_W'($urandom_range(0, 1023));
					end
					r = $urandom_range(0, 99);
					if (r < 70) begin
						w.add = $urandom_range(1, 64);
					end else if (r < 85) begin
						w.add = $urandom_range(0, 4096);
					end else if (r >= 95) begin
						w.add = '1;
					end
					send_word(w);
				end
				// sample total equals the count held up to a cut point
				cut    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 600) : NUM_BINS - 1;
				target = '0;
				for (int i = 0; i <= cut; i++) begin
					target = target + TOT_W'(hist_bins[i]);
				end
				w         = rand_word(MODE_MERGE_TOTALS);
				w.samples = target - hist_samples;
				w.maxv    = w.maxv >> $urandom_range(0, 63);
				send_word(w);
				repeat ($urandom_range(1, 3)) begin
					w = rand_word(MODE_QUERY);
					r = $urandom_range(0, 99);
					if (r < 10) begin
						w.frac = '0;
					end else if (r < 20) begin
						w.frac = FRAC_W'(65536);
					end else if (r < 90) begin
						w.frac = FRAC_W'($urandom_range(1, 65535));
					end else begin
						w.frac = FRAC_W'($urandom_range(65537, 131071));
					end
					send_word(w);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_word(rand_word(mode_t'($urandom_range(0, 3))));
				end
			end
			if ($urandom_range(0, 99) < 3) begin
				wait_results_drained();
			end
			seq_no++;
		end
		steady = 1'b0;
	endtask

	initial begin
		foreach (hist_bins[i]) begin
			hist_bins[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_queries();
		test_bucket_merge();
		test_totals_merge();
		test_idle_mode();
		test_query_edges();
		test_random_sequences();
		wait_results_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d words: %0d bucket merges (%0d saturating), %0d totals merges,",
			word_count, bucket_merges, saturations, totals_merges);
		$display("  %0d percentile queries (%0d reached), %0d mismatching words",
			queries, queries_found, errors);
		if (errors == 0) begin
			$display("log_histogram_merge_percentile_top regression: pass");
		end else begin
			$display("log_histogram_merge_percentile_top regression: fail");
		end
		$finish;
	end

endmodule
